// ===== hdl/khpb_pkg.sv =====
// shared types and constants for the key hold and press buffer
package khpb_pkg;

  // fixed widths of the key masks and counters
  localparam int KEY_W        = 16;
  localparam int HOLD_W       = 16;
  localparam int WINDOW_W     = 4;
  localparam logic [HOLD_W-1:0]   HOLD_MAX     = 16'hFFFF;
  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 4'd4;

  // what one key lane reports for the current item
  typedef struct packed {
    logic              query;
    logic              pressed;
    logic              held;
    logic              released;
    logic              buffered;
    logic [HOLD_W-1:0] hold;
  } lane_res_t;

endpackage

// ===== hdl/key_hold_and_press_buffer_unit.sv =====
// top level of the key hold and press buffer
//
// usage:
//   input channel: in_valid / in_stall with pressed_keys, held_keys,
//   released_keys and query_key; one item is one frame tick.
//   output channel: out_valid / out_stall with the four hit flags and
//   hold_frames; one result item per input item, in order.
//   config channel: cfg_valid / cfg_ready with cfg_data, the buffer window
//   (frames searched for a buffered press); cfg_ready is always high.
// result: registered; it appears in the cycle after its item is accepted.
// throughput: one item per cycle while not stalled; every key has its own lane that updates
//   its press age and hold counter in the accept cycle, and the merge stage
//   reduces the lanes into the output register in the same cycle.
// stall: while out_stall holds a full output register, in_stall is raised
//   and the lanes keep their state; the result holds until taken.
// reset: synchronous; clears every hold counter, marks every key as not
//   pressed within the history, empties the output register and sets the
//   buffer window to 4. No clearing pass is needed.
module key_hold_and_press_buffer_unit
  import khpb_pkg::*;
#(
  parameter int HISTORY_DEPTH = 8,
  parameter int KEY_COUNT     = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [KEY_W-1:0]    pressed_keys,
  input  logic [KEY_W-1:0]    held_keys,
  input  logic [KEY_W-1:0]    released_keys,
  input  logic [KEY_W-1:0]    query_key,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                pressed_hit,
  output logic                held_hit,
  output logic                released_hit,
  output logic                buffered_hit,
  output logic [HOLD_W-1:0]   hold_frames,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [WINDOW_W-1:0] cfg_data
);

  localparam int HOLD_KEYS = (KEY_COUNT < KEY_W) ? KEY_COUNT : KEY_W;

  logic                load;
  logic [WINDOW_W-1:0] buffer_window;
  lane_res_t           lanes [KEY_W];

  // handshake: take an item unless a finished result is stuck
  assign in_stall  = out_valid & out_stall;
  assign load      = in_valid & ~in_stall;
  assign cfg_ready = 1'b1;

  // buffer window register
  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_window <= WINDOW_RESET;
    end else if (cfg_valid && cfg_ready) begin
      buffer_window <= cfg_data;
    end
  end

  // one lane per key
  generate
    for (genvar k = 0; k < KEY_W; k++) begin : g_lane
      khpb_lane #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .HAS_HOLD      (k < HOLD_KEYS)
      ) u_lane (
        .clk      (clk),
        .rst      (rst),
        .update   (load),
        .pressed  (pressed_keys[k]),
        .held     (held_keys[k]),
        .released (released_keys[k]),
        .query    (query_key[k]),
        .window   (buffer_window),
        .res      (lanes[k])
      );
    end
  endgenerate

  // merge lanes into the output register
  khpb_merge #(
    .HOLD_KEYS (HOLD_KEYS)
  ) u_merge (
    .clk          (clk),
    .rst          (rst),
    .load         (load),
    .lanes        (lanes),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .pressed_hit  (pressed_hit),
    .held_hit     (held_hit),
    .released_hit (released_hit),
    .buffered_hit (buffered_hit),
    .hold_frames  (hold_frames)
  );

endmodule

// ===== hdl/khpb_lane.sv =====
// one key lane: frames-since-press age and hold counter for a single key
module khpb_lane
  import khpb_pkg::*;
#(
  parameter int HISTORY_DEPTH = 8,
  parameter bit HAS_HOLD      = 1'b1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                update,
  input  logic                pressed,
  input  logic                held,
  input  logic                released,
  input  logic                query,
  input  logic [WINDOW_W-1:0] window,
  output lane_res_t           res
);

  localparam int AGE_W = $clog2(HISTORY_DEPTH + 1);
  localparam int CMP_W = (AGE_W > WINDOW_W) ? AGE_W : WINDOW_W;
  localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(HISTORY_DEPTH);

  // frames since the last press, saturating at the history depth
  logic [AGE_W-1:0]  age;
  logic [AGE_W-1:0]  age_next;
  logic [HOLD_W-1:0] hold_next;
  logic [CMP_W-1:0]  age_x;
  logic [CMP_W-1:0]  window_x;
  logic [CMP_W-1:0]  depth_x;

  always_comb begin
    if (pressed) begin
      age_next = '0;
    end else if (age == AGE_MAX) begin
      age_next = age;
    end else begin
      age_next = age + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      age <= AGE_MAX;
    end else if (update) begin
      age <= age_next;
    end
  end

  // hold counter, only for keys that have one
  generate
    if (HAS_HOLD) begin : g_hold
      logic [HOLD_W-1:0] hold;

      always_comb begin
        if (!held) begin
          hold_next = '0;
        end else if (hold == HOLD_MAX) begin
          hold_next = hold;
        end else begin
          hold_next = hold + 1'b1;
        end
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          hold <= '0;
        end else if (update) begin
          hold <= hold_next;
        end
      end
    end else begin : g_no_hold
      assign hold_next = '0;
    end
  endgenerate

  // window test on the updated age
  assign age_x    = CMP_W'(age_next);
  assign window_x = CMP_W'(window);
  assign depth_x  = CMP_W'(HISTORY_DEPTH);

  assign res.query    = query;
  assign res.pressed  = query & pressed;
  assign res.held     = query & held;
  assign res.released = query & released;
  assign res.buffered = query & (age_x < window_x) & (age_x < depth_x);
  assign res.hold     = hold_next;

endmodule

// ===== hdl/khpb_merge.sv =====
// merging stage: combines lane results and holds the output register
module khpb_merge
  import khpb_pkg::*;
#(
  parameter int HOLD_KEYS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  lane_res_t         lanes [KEY_W],
  input  logic              out_stall,
  output logic              out_valid,
  output logic              pressed_hit,
  output logic              held_hit,
  output logic              released_hit,
  output logic              buffered_hit,
  output logic [HOLD_W-1:0] hold_frames
);

  logic [KEY_W-1:0]  qmask;
  logic [KEY_W-1:0]  lowest;
  logic              any_pressed;
  logic              any_held;
  logic              any_released;
  logic              any_buffered;
  logic [HOLD_W-1:0] hold_sel;

  // reduce the lane flags and pick the lowest queried key with a counter
  always_comb begin
    any_pressed  = 1'b0;
    any_held     = 1'b0;
    any_released = 1'b0;
    any_buffered = 1'b0;
    for (int k = 0; k < KEY_W; k++) begin
      any_pressed  = any_pressed  | lanes[k].pressed;
      any_held     = any_held     | lanes[k].held;
      any_released = any_released | lanes[k].released;
      any_buffered = any_buffered | lanes[k].buffered;
      qmask[k]     = lanes[k].query & (k < HOLD_KEYS);
    end
    lowest   = qmask & (~qmask + 1'b1);
    hold_sel = '0;
    for (int k = 0; k < KEY_W; k++) begin
      hold_sel = hold_sel | (lanes[k].hold & {HOLD_W{lowest[k]}});
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= load | (out_valid & out_stall);
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (load) begin
      pressed_hit  <= any_pressed;
      held_hit     <= any_held;
      released_hit <= any_released;
      buffered_hit <= any_buffered;
      hold_frames  <= hold_sel;
    end
  end

endmodule

// ===== hdl/khpb_checker.sv =====
// port-level checks for the key hold and press buffer, bound to the top level
module khpb_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic [15:0] query_key,
  input logic        out_valid,
  input logic        out_stall,
  input logic        buffered_hit,
  input logic [15:0] hold_frames
);

  // a stalled result stays valid
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");

  // an accepted item gives a result in the next cycle
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted item produced no result");

  // input stalls only behind a stuck result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stuck result");

  // empty query gives no buffered hit and zero hold count
  a_empty_query: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && query_key == 16'd0 |=> !buffered_hit && hold_frames == 16'd0)
    else $error("empty query gave a non-zero answer");

  // reset empties the output
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind key_hold_and_press_buffer_unit khpb_checker u_khpb_checker (.*);

// ===== sim/tb_key_hold_and_press_buffer_unit.sv =====
// self-checking testbench for the key hold and press buffer unit
module tb_key_hold_and_press_buffer_unit;
  import khpb_pkg::*;

  localparam int HISTORY_DEPTH = 8;
  localparam int KEY_COUNT     = 16;
  localparam int SLOT_W        = $clog2(HISTORY_DEPTH);
  localparam int STALL_LIMIT   = 1000;
  localparam int PRINT_LIMIT   = 100;

  // expected answer for one frame item
  typedef struct packed {
    logic              pressed_hit;
    logic              held_hit;
    logic              released_hit;
    logic              buffered_hit;
    logic [HOLD_W-1:0] hold_frames;
  } frame_answer_t;

  logic                clk           = 1'b0;
  logic                rst           = 1'b1;
  logic                in_valid      = 1'b0;
  logic                in_stall;
  logic [KEY_W-1:0]    pressed_keys  = '0;
  logic [KEY_W-1:0]    held_keys     = '0;
  logic [KEY_W-1:0]    released_keys = '0;
  logic [KEY_W-1:0]    query_key     = '0;
  logic                out_valid;
  logic                out_stall     = 1'b0;
  logic                pressed_hit;
  logic                held_hit;
  logic                released_hit;
  logic                buffered_hit;
  logic [HOLD_W-1:0]   hold_frames;
  logic                cfg_valid     = 1'b0;
  logic                cfg_ready;
  logic [WINDOW_W-1:0] cfg_data      = '0;

  // predictor state
  logic [KEY_W-1:0]    press_ring [HISTORY_DEPTH];
  logic [SLOT_W-1:0]   ring_slot;
  logic [HOLD_W-1:0]   hold_ctr [KEY_COUNT];
  logic [WINDOW_W-1:0] window_reg;
  frame_answer_t       expected_answers [$];

  // keys the random typist is holding down
  logic [KEY_W-1:0]    keys_down = '0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatch_count = 0;
  int results_seen = 0;
  int quiet_cycles = 0;

  key_hold_and_press_buffer_unit #(
    .HISTORY_DEPTH(HISTORY_DEPTH),
    .KEY_COUNT    (KEY_COUNT)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .pressed_keys (pressed_keys),
    .held_keys    (held_keys),
    .released_keys(released_keys),
    .query_key    (query_key),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pressed_hit  (pressed_hit),
    .held_hit     (held_hit),
    .released_hit (released_hit),
    .buffered_hit (buffered_hit),
    .hold_frames  (hold_frames),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  // clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // receiver back-pressure
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // one line per mismatch, printing capped to keep the log short
  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (mismatch_count < PRINT_LIMIT)
      $display("mismatch on %s at result %0d: got %0d, expected %0d",
               what, results_seen, got, want);
    mismatch_count++;
  endtask

  // compare every taken result with the oldest expected answer
  always @(posedge clk) begin : check_results
    frame_answer_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_answers.size() == 0) begin
        report_mismatch("unexpected result", 32'(hold_frames), 0);
      end else begin
        want = expected_answers.pop_front();
        if (pressed_hit !== want.pressed_hit)
          report_mismatch("pressed_hit", 32'(pressed_hit), 32'(want.pressed_hit));
        if (held_hit !== want.held_hit)
          report_mismatch("held_hit", 32'(held_hit), 32'(want.held_hit));
        if (released_hit !== want.released_hit)
          report_mismatch("released_hit", 32'(released_hit), 32'(want.released_hit));
        if (buffered_hit !== want.buffered_hit)
          report_mismatch("buffered_hit", 32'(buffered_hit), 32'(want.buffered_hit));
        if (hold_frames !== want.hold_frames)
          report_mismatch("hold_frames", 32'(hold_frames), 32'(want.hold_frames));
      end
      results_seen++;
    end
  end

  // watchdog on cycles where no handshake completes
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // work out the answer for one accepted frame and queue it
  task automatic predict_frame(input logic [KEY_W-1:0] pr, input logic [KEY_W-1:0] hd,
                               input logic [KEY_W-1:0] rl, input logic [KEY_W-1:0] qk);
    frame_answer_t ans;
    logic [SLOT_W-1:0] idx;
    int span;
    bit found;
    press_ring[ring_slot] = pr;
    ring_slot = ring_slot + 1'b1;
    // hold counters count while held, clear otherwise
    for (int k = 0; k < KEY_COUNT; k++) begin
      if (hd[k]) begin
        if (hold_ctr[k] != HOLD_MAX)
          hold_ctr[k] = hold_ctr[k] + 1'b1;
      end else begin
        hold_ctr[k] = '0;
      end
    end
    // newest frames first, window capped at the ring depth
    span = (window_reg > HISTORY_DEPTH) ? HISTORY_DEPTH : int'(window_reg);
    ans = '0;
    for (int i = 0; i < span; i++) begin
      idx = ring_slot - 1'b1 - SLOT_W'(i);
      if ((press_ring[idx] & qk) != '0)
        ans.buffered_hit = 1'b1;
    end
    // lowest set query bit picks the counter
    found = 1'b0;
    for (int k = 0; k < KEY_COUNT; k++) begin
      if (!found && qk[k]) begin
        ans.hold_frames = hold_ctr[k];
        found = 1'b1;
      end
    end
    ans.pressed_hit  = ((pr & qk) != '0);
    ans.held_hit     = ((hd & qk) != '0);
    ans.released_hit = ((rl & qk) != '0);
    expected_answers.push_back(ans);
  endtask

  // send one frame item; called and returns at a falling edge
  task automatic send_frame(input logic [KEY_W-1:0] pr, input logic [KEY_W-1:0] hd,
                            input logic [KEY_W-1:0] rl, input logic [KEY_W-1:0] qk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    pressed_keys  <= pr;
    held_keys     <= hd;
    released_keys <= rl;
    query_key     <= qk;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_frame(pr, hd, rl, qk);
    @(negedge clk);
  endtask

  // write the buffer window once every outstanding result is back
  task automatic write_window(input logic [WINDOW_W-1:0] value);
    in_valid <= 1'b0;
    @(negedge clk);
    while (expected_answers.size() != 0) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    window_reg = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  // mostly one or two keys, sometimes none or a wide random mask
  function automatic logic [KEY_W-1:0] pick_query();
    int choice;
    choice = $urandom_range(99);
    if (choice < 5)
      return '0;
    else if (choice < 55)
      return KEY_W'(1) << $urandom_range(KEY_W-1);
    else if (choice < 80)
      return (KEY_W'(1) << $urandom_range(KEY_W-1)) | (KEY_W'(1) << $urandom_range(KEY_W-1));
    else
      return KEY_W'($urandom);
  endfunction

  // edge cases at the reset window
  task automatic test_directed_cases();
    send_frame('0, '0, '0, '0);
    send_frame('1, '1, '1, '1);
    // top key only, counter at two
    send_frame('0, '1, '0, 16'h8000);
    // empty query with everything set
    send_frame('1, '1, '1, '0);
    // released mark alone, counters clear because nothing is held
    send_frame('0, '0, '1, 16'h0001);
    // released together with held keeps counting
    send_frame('0, 16'h0001, 16'h0001, 16'h0001);
    send_frame('0, 16'h0001, '0, 16'h0001);
    send_frame('0, 16'h0001, '0, 16'h0003);
    send_frame('0, '0, '0, 16'h0002);
    // press ages out of the default window of four frames
    send_frame(16'h0004, 16'h0004, '0, 16'h0004);
    for (int i = 0; i < 5; i++)
      send_frame('0, 16'h0004, '0, 16'h0004);
    send_frame(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
    send_frame(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
    send_frame('0, '0, '0, 16'hFFFF);
  endtask

  // one press then quiet frames across the window extremes
  task automatic test_window_sweep();
    logic [WINDOW_W-1:0] widths [6];
    logic [KEY_W-1:0] key;
    widths = '{4'd0, 4'd1, 4'd8, 4'd9, 4'd15, 4'd3};
    foreach (widths[w]) begin
      write_window(widths[w]);
      key = KEY_W'(1) << $urandom_range(KEY_W-1);
      send_frame(key, key, '0, key);
      for (int i = 0; i < HISTORY_DEPTH; i++)
        send_frame('0, '0, (i == 0) ? key : '0, key);
    end
  endtask

  // plausible typing with some noise frames mixed in
  task automatic test_random_typing(input int frames);
    logic [KEY_W-1:0] next_down;
    logic [WINDOW_W-1:0] width;
    width = ($urandom_range(3) == 0) ? WINDOW_W'($urandom_range(15))
                                     : WINDOW_W'($urandom_range(1, HISTORY_DEPTH));
    write_window(width);
    for (int n = 0; n < frames; n++) begin
      if ($urandom_range(99) < 15) begin
        send_frame(KEY_W'($urandom), KEY_W'($urandom), KEY_W'($urandom), KEY_W'($urandom));
      end else begin
        next_down = keys_down ^ KEY_W'($urandom & $urandom & $urandom);
        send_frame(next_down & ~keys_down, next_down, keys_down & ~next_down, pick_query());
        keys_down = next_down;
      end
    end
  endtask

  // hold every key for a long run, then drop some and re-hold
  task automatic test_hold_and_release();
    logic [KEY_W-1:0] held;
    write_window(WINDOW_W'(HISTORY_DEPTH));
    for (int n = 0; n < 40; n++)
      send_frame(KEY_W'($urandom & $urandom), '1, '0, pick_query());
    for (int n = 0; n < 20; n++) begin
      held = KEY_W'($urandom | $urandom);
      send_frame('0, held, ~held, pick_query());
    end
    keys_down = '0;
  endtask

  initial begin
    for (int i = 0; i < HISTORY_DEPTH; i++) press_ring[i] = '0;
    for (int k = 0; k < KEY_COUNT; k++) hold_ctr[k] = '0;
    ring_slot  = '0;
    window_reg = WINDOW_RESET;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    set_idling(13, 67);
    test_directed_cases();
    test_window_sweep();
    test_random_typing(205);
    test_random_typing(205);

    set_idling(67, 13);
    test_random_typing(205);
    test_random_typing(205);

    set_idling(0, 0);
    test_hold_and_release();
    test_random_typing(205);
    test_random_typing(205);

    // drain and let the pipeline settle
    in_valid <= 1'b0;
    @(negedge clk);
    while (expected_answers.size() != 0) @(negedge clk);
    repeat (5) @(negedge clk);
    if (mismatch_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/khpb_pkg.sv
hdl/khpb_lane.sv
hdl/khpb_merge.sv
hdl/key_hold_and_press_buffer_unit.sv
hdl/khpb_checker.sv
sim/tb_key_hold_and_press_buffer_unit.sv
